// File: rtl/core/sha_pkg.sv
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [8];

  // Message schedule taps, as word positions in the 16-word window.
  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w9;
    word_t w14;
  } sched_taps_t;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS      = 64;
  localparam logic [7:0]  PAD_MARKER  = 8'h80;
  localparam logic [5:0]  LEN_START   = 6'd56;
  localparam logic [5:0]  LAST_FILL   = 6'd63;
  localparam logic [5:0]  LAST_ROUND  = 6'd63;
  localparam logic [2:0]  LAST_WORD   = 3'd7;

  localparam hash_t H_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t ror(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// File: rtl/core/sha_round.sv
module sha_round (
  input  sha_pkg::hash_t       vars_in,
  input  sha_pkg::word_t       k_word,
  input  sha_pkg::sched_taps_t taps,
  output sha_pkg::hash_t       vars_out,
  output sha_pkg::word_t       sched_new
);

  sha_pkg::word_t big_s0, big_s1, ch, maj, t1, t2, small_s0, small_s1;

  always_comb begin
    big_s1 = sha_pkg::ror(vars_in[4], 6) ^ sha_pkg::ror(vars_in[4], 11)
           ^ sha_pkg::ror(vars_in[4], 25);
    ch     = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
    big_s0 = sha_pkg::ror(vars_in[0], 2) ^ sha_pkg::ror(vars_in[0], 13)
           ^ sha_pkg::ror(vars_in[0], 22);
    maj    = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
           ^ (vars_in[1] & vars_in[2]);
    t1     = vars_in[7] + big_s1 + ch + k_word + taps.w0;
    t2     = big_s0 + maj;

    vars_out[0] = t1 + t2;
    vars_out[1] = vars_in[0];
    vars_out[2] = vars_in[1];
    vars_out[3] = vars_in[2];
    vars_out[4] = vars_in[3] + t1;
    vars_out[5] = vars_in[4];
    vars_out[6] = vars_in[5];
    vars_out[7] = vars_in[6];

    // extend the schedule by one word
    small_s0  = sha_pkg::ror(taps.w1, 7) ^ sha_pkg::ror(taps.w1, 18) ^ (taps.w1 >> 3);
    small_s1  = sha_pkg::ror(taps.w14, 17) ^ sha_pkg::ror(taps.w14, 19) ^ (taps.w14 >> 10);
    sched_new = taps.w0 + small_s0 + taps.w9 + small_s1;
  end

endmodule

// File: rtl/core/sha256_stream_hasher.sv
// Streaming SHA-256: one request per cycle while idle, at most one byte per request.
// Every 64th byte starts a compression: 64 rounds of the shared round unit plus a fold step.
// End of message: 9 to 72 padding bytes, one or two compressions,
// then eight digest words, one per cycle while the consumer takes them.
// Reset (rst, synchronous): hash to initial values, counts zero; byte buffer kept.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  // Sequencer: IDLE takes requests, PAD feeds padding bytes one a cycle,
  // ROUND runs the shared round unit, FOLD adds into the hash, OUT drains.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state, resume;

  // Byte buffer doubles as the 16-word schedule window; oldest byte on top.
  logic [63:0][7:0]  block_bytes;
  logic [5:0]        fill;
  logic [60:0]       msg_len;
  logic              marker_done;
  logic              len_phase;
  logic [5:0]        rnd;
  logic [2:0]        out_idx;
  sha_pkg::hash_t    hash;
  sha_pkg::hash_t    vars;
  sha_pkg::hash_t    vars_next;
  sha_pkg::word_t    sched_new;
  sha_pkg::sched_taps_t taps;

  logic              msg_fire;
  logic              out_fire;
  logic              put_byte;
  logic [7:0]        put_val;
  logic              start_comp;
  logic              pad_in_len;
  logic [7:0]        pad_byte;
  logic [7:0][7:0]   len_bytes;

  assign msg_ready    = (state == ST_IDLE);
  assign msg_fire     = msg_valid && msg_ready;
  assign digest_valid = (state == ST_OUT);
  assign out_fire     = digest_valid && digest_ready;
  assign digest_word  = hash[0];
  assign word_index   = out_idx;
  assign last_word    = (out_idx == sha_pkg::LAST_WORD);

  // Length field goes in once the marker is placed and fill reaches 56.
  assign len_bytes  = {msg_len, 3'b000};
  assign pad_in_len = marker_done && (len_phase || fill == sha_pkg::LEN_START);
  always_comb begin
    if (!marker_done) begin
      pad_byte = sha_pkg::PAD_MARKER;
    end else if (pad_in_len) begin
      pad_byte = len_bytes[~fill[2:0]];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign put_byte   = (msg_fire && has_byte) || (state == ST_PAD);
  assign put_val    = (state == ST_PAD) ? pad_byte : data_byte;
  assign start_comp = put_byte && (fill == sha_pkg::LAST_FILL);

  assign taps.w0  = block_bytes[63:60];
  assign taps.w1  = block_bytes[59:56];
  assign taps.w9  = block_bytes[27:24];
  assign taps.w14 = block_bytes[7:4];

  sha_round u_round (
    .vars_in   (vars),
    .k_word    (sha_pkg::round_k(rnd)),
    .taps      (taps),
    .vars_out  (vars_next),
    .sched_new (sched_new)
  );

  // Datapath: byte window and working variables.
  always_ff @(posedge clk) begin
    if (put_byte) begin
      block_bytes <= {block_bytes[62:0], put_val};
    end else if (state == ST_ROUND) begin
      block_bytes <= {block_bytes[59:0], sched_new};
    end
    if (start_comp) begin
      vars <= hash;
    end else if (state == ST_ROUND) begin
      vars <= vars_next;
    end
  end

  // Control and hash state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      resume      <= ST_IDLE;
      fill        <= '0;
      msg_len     <= '0;
      marker_done <= 1'b0;
      len_phase   <= 1'b0;
      rnd         <= '0;
      out_idx     <= '0;
      hash        <= sha_pkg::H_INIT;
    end else begin
      if (put_byte) begin
        fill <= fill + 6'd1;
      end
      case (state)
        ST_IDLE: begin
          if (msg_fire) begin
            if (has_byte) begin
              msg_len <= msg_len + 61'd1;
            end
            if (start_comp) begin
              state  <= ST_ROUND;
              resume <= end_of_message ? ST_PAD : ST_IDLE;
            end else if (end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          marker_done <= 1'b1;
          if (pad_in_len) begin
            len_phase <= 1'b1;
          end
          if (start_comp) begin
            state  <= ST_ROUND;
            resume <= pad_in_len ? ST_OUT : ST_PAD;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == sha_pkg::LAST_ROUND) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + vars[i];
          end
          state <= resume;
        end
        ST_OUT: begin
          // shift the digest out and the initial values in behind it
          if (out_fire) begin
            for (int i = 0; i < 7; i++) begin
              hash[i] <= hash[i + 1];
            end
            hash[7] <= sha_pkg::H_INIT[out_idx];
            out_idx <= out_idx + 3'd1;
            if (last_word) begin
              state       <= ST_IDLE;
              msg_len     <= '0;
              marker_done <= 1'b0;
              len_phase   <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && digest_valid))
    else $error("request and digest sides active together");

  a_word_advance: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last_word) |=> (digest_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest word index did not advance");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last_word) |=> (msg_ready && fill == 6'd0 && msg_len == 61'd0))
    else $error("block not clean after last digest word");

  a_rounds_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd != sha_pkg::LAST_ROUND) |=> (state == ST_ROUND))
    else $error("compression left before round 63");

  a_comp_on_wrap: assert property (@(posedge clk) disable iff (rst)
    start_comp |=> (state == ST_ROUND && rnd == 6'd0 && fill == 6'd0))
    else $error("compression did not start on a full block");

endmodule
